FILE: src/ip6fmt_pkg.sv
// Shared types, character codes and digit helpers for the IPv6 address text formatter.
// No dependencies; used by ipv6_address_text_formatter.

package ip6fmt_pkg;

   // Input item: the address as two 64-bit halves, network byte order
   typedef struct packed {
      logic [63:0] addr_high;
      logic [63:0] addr_low;
   } req_type;

   // Result item: one ASCII character of the text
   typedef struct packed {
      logic [6:0] text_char;
      logic       last;
   } rsp_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_GRP,
      ST_HEX,
      ST_TAIL,
      ST_E_COL1,
      ST_E_COL2,
      ST_E_COL3,
      ST_E_DEC,
      ST_E_DOT
   } state_type;

   // ASCII codes
   localparam logic [6:0] CHAR_COLON = 7'h3a;
   localparam logic [6:0] CHAR_DOT   = 7'h2e;
   localparam logic [6:0] CHAR_ZERO  = 7'h30;
   localparam logic [6:0] CHAR_A     = 7'h61;

   // Groups that select the embedded IPv4 form
   localparam logic [15:0] GRP_ISATAP = 16'h5efe;
   localparam logic [15:0] GRP_MAPPED = 16'hffff;

   // Lower-case hex digit
   function automatic logic [6:0] hex_char(input logic [3:0] nib);
      logic [6:0] c;
      if (nib < 4'd10) begin
         c = CHAR_ZERO + {3'b000, nib};
      end else begin
         c = CHAR_A + {3'b000, nib} - 7'd10;
      end
      return c;
   endfunction

   // Index of the most significant printed hex digit (no leading zeros)
   function automatic logic [1:0] hex_top_dig(input logic [15:0] g);
      logic [1:0] d;
      if (g >= 16'h1000) begin
         d = 2'd3;
      end else if (g >= 16'h0100) begin
         d = 2'd2;
      end else if (g >= 16'h0010) begin
         d = 2'd1;
      end else begin
         d = 2'd0;
      end
      return d;
   endfunction

   // Index of the most significant printed decimal digit of a byte
   function automatic logic [1:0] dec_top_dig(input logic [7:0] b);
      logic [1:0] d;
      if (b >= 8'd100) begin
         d = 2'd2;
      end else if (b >= 8'd10) begin
         d = 2'd1;
      end else begin
         d = 2'd0;
      end
      return d;
   endfunction

   // Byte to three BCD digits, shift-and-add-3 over the eight bits
   function automatic logic [11:0] dec_bcd(input logic [7:0] b);
      logic [11:0] bcd;
      bcd = '0;
      for (int i = 7; i >= 0; i--) begin
         if (bcd[3:0] >= 4'd5) bcd[3:0] = bcd[3:0] + 4'd3;
         if (bcd[7:4] >= 4'd5) bcd[7:4] = bcd[7:4] + 4'd3;
         bcd = {bcd[10:0], b[i]};
      end
      return bcd;
   endfunction

endpackage

FILE: src/ipv6_address_text_formatter.sv
// Steps: an accept in idle and a scan of the eight groups (one zero compare per group), then
// one character per step, a step waiting while the receiver stalls, plus one silent step for
// group 0 when it is printed and for each later group of a compressed zero run. req_ready is
// high only while idle. The output register lets the last character wait during the next scan.
// Synchronous active-high reset returns the sequencer to idle and empties the output.
// IPv6 address to canonical text, one character per result item; depends on ip6fmt_pkg.

module ipv6_address_text_formatter (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ip6fmt_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ip6fmt_pkg::rsp_type rsp_data
);

   ip6fmt_pkg::state_type state_ff, state_in;

   // Working registers
   logic [127:0] addr_ff, addr_in;
   logic [2:0]   idx_ff, idx_in;
   logic [1:0]   dig_ff, dig_in;
   logic [1:0]   byte_ff, byte_in;
   logic [3:0]   cur_len_ff, cur_len_in;
   logic [3:0]   best_len_ff, best_len_in;
   logic [2:0]   best_start_ff, best_start_in;
   logic         top_zero_ff, top_zero_in;
   logic         g5_isatap_ff, g5_isatap_in;
   logic         g5_mapped_ff, g5_mapped_in;
   logic         g5_zero_ff, g5_zero_in;
   logic         g6_nz_ff, g6_nz_in;
   logic         embed_ff, embed_in;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   ip6fmt_pkg::rsp_type rsp_ff, rsp_in;

   // Shared decode
   logic        accept;
   logic        step;
   logic [15:0] cur_grp;
   logic [3:0]  cur_nib;
   logic        grp_zero;
   logic [3:0]  run_end;
   logic        compress;
   logic        in_run;
   logic [7:0]  cur_byte;
   logic [1:0]  ld_sel;
   logic [7:0]  ld_byte;
   logic [11:0] bcd;
   logic [3:0]  dec_nib;
   logic        emit;
   logic [6:0]  emit_char;
   logic        emit_last;

   assign accept    = (state_ff == ip6fmt_pkg::ST_IDLE) && req_valid;
   assign step      = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ip6fmt_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Current group: top of the rotating word, or group 5 in the embedded form
   assign cur_grp  = embed_ff ? addr_ff[47:32] : addr_ff[127:112];
   assign cur_nib  = 4'(cur_grp >> {dig_ff, 2'b00});
   assign grp_zero = (addr_ff[127:112] == 16'h0000);

   // Zero-run window
   assign run_end  = {1'b0, best_start_ff} + best_len_ff;
   assign compress = (best_len_ff >= 4'd2);
   assign in_run   = compress && (idx_ff >= best_start_ff) && ({1'b0, idx_ff} < run_end);

   // IPv4 bytes, byte 0 in bits 31:24
   assign cur_byte = 8'(addr_ff[31:0] >> {~byte_ff, 3'b000});
   assign ld_sel   = (state_ff == ip6fmt_pkg::ST_E_DOT) ? byte_ff + 2'd1 : byte_ff;
   assign ld_byte  = 8'(addr_ff[31:0] >> {~ld_sel, 3'b000});
   assign bcd      = ip6fmt_pkg::dec_bcd(cur_byte);
   assign dec_nib  = 4'(bcd >> {dig_ff, 2'b00});

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ip6fmt_pkg::ST_IDLE: begin
            if (req_valid) state_in = ip6fmt_pkg::ST_SCAN;
         end
         ip6fmt_pkg::ST_SCAN: begin
            if (idx_ff == 3'd7) begin
               state_in = embed_in ? ip6fmt_pkg::ST_E_COL1 : ip6fmt_pkg::ST_GRP;
            end
         end
         ip6fmt_pkg::ST_GRP: begin
            if (step) begin
               if (!in_run) begin
                  state_in = ip6fmt_pkg::ST_HEX;
               end else if (idx_ff == 3'd7) begin
                  state_in = ip6fmt_pkg::ST_TAIL;
               end
            end
         end
         ip6fmt_pkg::ST_HEX: begin
            if (step && dig_ff == 2'd0) begin
               if (embed_ff) begin
                  state_in = ip6fmt_pkg::ST_E_COL3;
               end else if (idx_ff == 3'd7) begin
                  state_in = ip6fmt_pkg::ST_IDLE;
               end else begin
                  state_in = ip6fmt_pkg::ST_GRP;
               end
            end
         end
         ip6fmt_pkg::ST_TAIL: begin
            if (step) state_in = ip6fmt_pkg::ST_IDLE;
         end
         ip6fmt_pkg::ST_E_COL1: begin
            if (step) state_in = ip6fmt_pkg::ST_E_COL2;
         end
         ip6fmt_pkg::ST_E_COL2: begin
            if (step) state_in = g5_zero_ff ? ip6fmt_pkg::ST_E_DEC : ip6fmt_pkg::ST_HEX;
         end
         ip6fmt_pkg::ST_E_COL3: begin
            if (step) state_in = ip6fmt_pkg::ST_E_DEC;
         end
         ip6fmt_pkg::ST_E_DEC: begin
            if (step && dig_ff == 2'd0) begin
               state_in = (byte_ff == 2'd3) ? ip6fmt_pkg::ST_IDLE : ip6fmt_pkg::ST_E_DOT;
            end
         end
         ip6fmt_pkg::ST_E_DOT: begin
            if (step) state_in = ip6fmt_pkg::ST_E_DEC;
         end
         default: state_in = ip6fmt_pkg::ST_IDLE;
      endcase
   end

   // Character produced by the current step
   always_comb begin
      emit      = 1'b0;
      emit_char = ip6fmt_pkg::CHAR_COLON;
      emit_last = 1'b0;
      unique case (state_ff)
         ip6fmt_pkg::ST_GRP: begin
            emit = in_run ? (idx_ff == best_start_ff) : (idx_ff != 3'd0);
         end
         ip6fmt_pkg::ST_HEX: begin
            emit      = 1'b1;
            emit_char = ip6fmt_pkg::hex_char(cur_nib);
            emit_last = (dig_ff == 2'd0) && !embed_ff && (idx_ff == 3'd7);
         end
         ip6fmt_pkg::ST_TAIL: begin
            emit      = 1'b1;
            emit_last = 1'b1;
         end
         ip6fmt_pkg::ST_E_COL1, ip6fmt_pkg::ST_E_COL2, ip6fmt_pkg::ST_E_COL3: begin
            emit = 1'b1;
         end
         ip6fmt_pkg::ST_E_DEC: begin
            emit      = 1'b1;
            emit_char = ip6fmt_pkg::CHAR_ZERO + {3'b000, dec_nib};
            emit_last = (dig_ff == 2'd0) && (byte_ff == 2'd3);
         end
         ip6fmt_pkg::ST_E_DOT: begin
            emit      = 1'b1;
            emit_char = ip6fmt_pkg::CHAR_DOT;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (step && emit) begin
         rsp_valid_in     = 1'b1;
         rsp_in.text_char = emit_char;
         rsp_in.last      = emit_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Datapath: zero-run scan, group rotation, digit and byte counters
   always_comb begin
      addr_in       = addr_ff;
      idx_in        = idx_ff;
      dig_in        = dig_ff;
      byte_in       = byte_ff;
      cur_len_in    = cur_len_ff;
      best_len_in   = best_len_ff;
      best_start_in = best_start_ff;
      top_zero_in   = top_zero_ff;
      g5_isatap_in  = g5_isatap_ff;
      g5_mapped_in  = g5_mapped_ff;
      g5_zero_in    = g5_zero_ff;
      g6_nz_in      = g6_nz_ff;
      embed_in      = embed_ff;
      case (state_ff)
         ip6fmt_pkg::ST_IDLE: begin
            if (accept) begin
               addr_in       = {req_data.addr_high, req_data.addr_low};
               idx_in        = '0;
               dig_in        = '0;
               byte_in       = '0;
               cur_len_in    = '0;
               best_len_in   = '0;
               best_start_in = '0;
               top_zero_in   = 1'b1;
               g5_isatap_in  = 1'b0;
               g5_mapped_in  = 1'b0;
               g5_zero_in    = 1'b0;
               g6_nz_in      = 1'b0;
               embed_in      = 1'b0;
            end
         end
         ip6fmt_pkg::ST_SCAN: begin
            // one group per cycle; the word is back in place after eight rotations
            addr_in = {addr_ff[111:0], addr_ff[127:112]};
            idx_in  = idx_ff + 3'd1;
            if (grp_zero) begin
               cur_len_in = cur_len_ff + 4'd1;
               if (cur_len_ff + 4'd1 > best_len_ff) begin
                  best_len_in   = cur_len_ff + 4'd1;
                  best_start_in = idx_ff - cur_len_ff[2:0];
               end
            end else begin
               cur_len_in = '0;
            end
            if (idx_ff < 3'd5) top_zero_in = top_zero_ff && grp_zero;
            if (idx_ff == 3'd5) begin
               g5_isatap_in = (addr_ff[127:112] == ip6fmt_pkg::GRP_ISATAP);
               g5_mapped_in = (addr_ff[127:112] == ip6fmt_pkg::GRP_MAPPED);
               g5_zero_in   = grp_zero;
            end
            if (idx_ff == 3'd6) g6_nz_in = !grp_zero;
            if (idx_ff == 3'd7) begin
               embed_in = top_zero_ff &&
                          (g5_isatap_ff || ((g5_mapped_ff || g5_zero_ff) && g6_nz_ff));
            end
         end
         ip6fmt_pkg::ST_GRP: begin
            if (step) begin
               if (in_run) begin
                  addr_in = {addr_ff[111:0], addr_ff[127:112]};
                  idx_in  = idx_ff + 3'd1;
               end else begin
                  dig_in = ip6fmt_pkg::hex_top_dig(cur_grp);
               end
            end
         end
         ip6fmt_pkg::ST_HEX: begin
            if (step) begin
               if (dig_ff != 2'd0) begin
                  dig_in = dig_ff - 2'd1;
               end else if (!embed_ff && idx_ff != 3'd7) begin
                  addr_in = {addr_ff[111:0], addr_ff[127:112]};
                  idx_in  = idx_ff + 3'd1;
               end
            end
         end
         ip6fmt_pkg::ST_E_COL2: begin
            if (step) begin
               dig_in = g5_zero_ff ? ip6fmt_pkg::dec_top_dig(ld_byte)
                                   : ip6fmt_pkg::hex_top_dig(cur_grp);
            end
         end
         ip6fmt_pkg::ST_E_COL3: begin
            if (step) dig_in = ip6fmt_pkg::dec_top_dig(ld_byte);
         end
         ip6fmt_pkg::ST_E_DEC: begin
            if (step && dig_ff != 2'd0) dig_in = dig_ff - 2'd1;
         end
         ip6fmt_pkg::ST_E_DOT: begin
            if (step) begin
               byte_in = byte_ff + 2'd1;
               dig_in  = ip6fmt_pkg::dec_top_dig(ld_byte);
            end
         end
         default: begin
            addr_in = addr_ff;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ip6fmt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      idx_ff        <= idx_in;
      dig_ff        <= dig_in;
      byte_ff       <= byte_in;
      cur_len_ff    <= cur_len_in;
      best_len_ff   <= best_len_in;
      best_start_ff <= best_start_in;
      top_zero_ff   <= top_zero_in;
      g5_isatap_ff  <= g5_isatap_in;
      g5_mapped_ff  <= g5_mapped_in;
      g5_zero_ff    <= g5_zero_in;
      g6_nz_ff      <= g6_nz_in;
      embed_ff      <= embed_in;
      rsp_ff        <= rsp_in;
   end

   // Scan always ends after the eighth group
   a_scan_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ip6fmt_pkg::ST_SCAN && idx_ff == 3'd7) |=> state_ff != ip6fmt_pkg::ST_SCAN)
      else $error("scan did not end after eight groups");

   // The chosen zero run lies inside the address
   a_run_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ip6fmt_pkg::ST_GRP) |-> (run_end <= 4'd8 && best_len_ff <= 4'd8))
      else $error("zero run exceeds the eight groups");

   // Group walk never happens in the embedded IPv4 form
   a_grp_not_embed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ip6fmt_pkg::ST_GRP || state_ff == ip6fmt_pkg::ST_TAIL) |-> !embed_ff)
      else $error("group walk in embedded form");

   // The final character of an item returns the sequencer to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (step && emit && emit_last) |=> state_ff == ip6fmt_pkg::ST_IDLE)
      else $error("last character without return to idle");

   // Nothing new is accepted before the final character has been loaded
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ip6fmt_pkg::ST_IDLE && state_ff != ip6fmt_pkg::ST_SCAN &&
       state_in == ip6fmt_pkg::ST_IDLE) |-> (step && emit && emit_last))
      else $error("item ended without a last character");

endmodule

FILE: test/tb.sv
// Self-checking bench for ipv6_address_text_formatter: predicts the canonical text of
// each accepted address and checks every character item against it, in order.
// Depends on ip6fmt_pkg and the formatter RTL.

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_RANDOM     = 100;
   localparam int ACCEPT_TIMEOUT = 5000;
   localparam int LONG_HOLD      = 400;
   localparam int HOLD_AFTER     = 30;
   localparam int DRAIN_CYCLES   = 60;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   ip6fmt_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   ip6fmt_pkg::rsp_type rsp_data;

   ipv6_address_text_formatter u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Addresses waiting to be offered, and characters the block still owes us
   ip6fmt_pkg::req_type pending_addrs[$];
   ip6fmt_pkg::rsp_type expected_chars[$];
   logic [6:0] text_buf[$];

   int   total_items    = 0;
   int   items_accepted = 0;
   int   error_count    = 0;
   int   idle_cycles    = 0;
   logic req_fired      = 1'b0;
   ip6fmt_pkg::rsp_type exp_char;

   // Sender burst/gap bookkeeping
   int burst_left = 0;
   int gap_left   = 0;

   // Receiver stall pattern
   int   rx_count  = 0;
   int   rx_mode   = 0;
   int   hold_left = 0;
   logic hold_done = 1'b0;

   initial begin
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Text prediction
   // ------------------------------------------------------------------

   function automatic logic [6:0] nibble_ascii(input logic [3:0] nib);
      if (nib < 4'd10) return ip6fmt_pkg::CHAR_ZERO + {3'b000, nib};
      return ip6fmt_pkg::CHAR_A + {3'b000, nib} - 7'd10;
   endfunction

   // Hex group without leading zeros
   function void push_hex(input logic [15:0] g);
      if (g >= 16'h1000) text_buf.push_back(nibble_ascii(g[15:12]));
      if (g >= 16'h0100) text_buf.push_back(nibble_ascii(g[11:8]));
      if (g >= 16'h0010) text_buf.push_back(nibble_ascii(g[7:4]));
      text_buf.push_back(nibble_ascii(g[3:0]));
   endfunction

   // Decimal byte without leading zeros
   function void push_dec(input logic [7:0] b);
      if (b >= 8'd100) text_buf.push_back(ip6fmt_pkg::CHAR_ZERO + 7'(b / 100));
      if (b >= 8'd10) text_buf.push_back(ip6fmt_pkg::CHAR_ZERO + 7'((b / 10) % 10));
      text_buf.push_back(ip6fmt_pkg::CHAR_ZERO + 7'(b % 10));
   endfunction

   function void format_address(input ip6fmt_pkg::req_type a);
      logic [15:0] grp [8];
      logic        top_zero;
      logic        embed;
      logic        compress;
      int          run_at;
      int          run_len;
      int          i;
      int          j;
      ip6fmt_pkg::rsp_type c;
      text_buf.delete();
      for (i = 0; i < 4; i++) begin
         grp[i]     = a.addr_high[63 - 16 * i -: 16];
         grp[i + 4] = a.addr_low[63 - 16 * i -: 16];
      end
      top_zero = (grp[0] == 0) && (grp[1] == 0) && (grp[2] == 0) &&
                 (grp[3] == 0) && (grp[4] == 0);
      embed = top_zero && (grp[5] == ip6fmt_pkg::GRP_ISATAP ||
                           ((grp[5] == ip6fmt_pkg::GRP_MAPPED || grp[5] == 0) &&
                            grp[6] != 0));

      if (embed) begin
         // "::" [group 5 ":"] a.b.c.d
         text_buf.push_back(ip6fmt_pkg::CHAR_COLON);
         text_buf.push_back(ip6fmt_pkg::CHAR_COLON);
         if (grp[5] != 0) begin
            push_hex(grp[5]);
            text_buf.push_back(ip6fmt_pkg::CHAR_COLON);
         end
         push_dec(a.addr_low[31:24]);
         text_buf.push_back(ip6fmt_pkg::CHAR_DOT);
         push_dec(a.addr_low[23:16]);
         text_buf.push_back(ip6fmt_pkg::CHAR_DOT);
         push_dec(a.addr_low[15:8]);
         text_buf.push_back(ip6fmt_pkg::CHAR_DOT);
         push_dec(a.addr_low[7:0]);
      end else begin
         // Earliest longest run of zero groups
         run_at  = 0;
         run_len = 0;
         i = 0;
         while (i < 8) begin
            if (grp[i] == 0) begin
               j = i;
               while (j < 8 && grp[j] == 0) j++;
               if (j - i > run_len) begin
                  run_len = j - i;
                  run_at  = i;
               end
               i = j;
            end else begin
               i++;
            end
         end
         compress = (run_len >= 2);
         for (i = 0; i < 8; i++) begin
            if (compress && i >= run_at && i < run_at + run_len) begin
               if (i == run_at) text_buf.push_back(ip6fmt_pkg::CHAR_COLON);
            end else begin
               if (i != 0) text_buf.push_back(ip6fmt_pkg::CHAR_COLON);
               push_hex(grp[i]);
            end
         end
         if (compress && run_at + run_len == 8) text_buf.push_back(ip6fmt_pkg::CHAR_COLON);
      end

      for (i = 0; i < text_buf.size(); i++) begin
         c.text_char = text_buf[i];
         c.last      = (i == text_buf.size() - 1);
         expected_chars.push_back(c);
      end
   endfunction

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   function void add_addr(input logic [63:0] hi, input logic [63:0] lo);
      ip6fmt_pkg::req_type r;
      r.addr_high = hi;
      r.addr_low  = lo;
      pending_addrs.push_back(r);
   endfunction

   // Random group with 1 to 4 significant hex digits
   function automatic logic [15:0] rand_group();
      logic [15:0] g;
      g = 16'($urandom_range(0, 65535));
      return g >> (4 * $urandom_range(0, 3));
   endfunction

   // Random byte with 1, 2 or 3 decimal digits
   function automatic logic [7:0] rand_byte();
      case ($urandom_range(0, 2))
         0:       return 8'($urandom_range(0, 9));
         1:       return 8'($urandom_range(10, 99));
         default: return 8'($urandom_range(100, 255));
      endcase
   endfunction

   function void add_random_addr();
      logic [15:0] grp [8];
      int          i;
      case ($urandom_range(0, 9))
         0, 1: begin
            add_addr({$urandom, $urandom}, {$urandom, $urandom});
         end
         2, 3, 4: begin
            // Near the embedded IPv4 prefix
            grp[5] = 16'h0000;
            case ($urandom_range(0, 3))
               0: grp[5] = 16'h0000;
               1: grp[5] = ip6fmt_pkg::GRP_MAPPED;
               2: grp[5] = ip6fmt_pkg::GRP_ISATAP;
               default: grp[5] = rand_group();
            endcase
            add_addr(($urandom_range(0, 7) == 0) ? {48'h0, rand_group()} : 64'h0,
                     {16'h0, grp[5],
                      ($urandom_range(0, 3) == 0) ? 16'h0 : {rand_byte(), rand_byte()},
                      ($urandom_range(0, 3) == 0) ? 16'h0 : {rand_byte(), rand_byte()}});
         end
         default: begin
            // Mixed zero and nonzero groups: runs, ties, single zeros
            for (i = 0; i < 8; i++) begin
               grp[i] = ($urandom_range(0, 99) < 45) ? 16'h0 : rand_group();
            end
            add_addr({grp[0], grp[1], grp[2], grp[3]}, {grp[4], grp[5], grp[6], grp[7]});
         end
      endcase
   endfunction

   initial begin
      int k;
      // Directed addresses
      add_addr(64'h0, 64'h0);                                    // all zero
      add_addr('1, '1);                                          // all ones
      add_addr(64'h0, 64'h1);                                    // loopback
      add_addr(64'h0, 64'h0000_ffff_0102_0304);                  // mapped v4
      add_addr(64'h0, 64'h0000_ffff_ffff_ffff);                  // mapped, 3-digit bytes
      add_addr(64'h0, 64'h0000_ffff_090a_6364);                  // 9.10.99.100
      add_addr(64'h0, 64'h0000_ffff_0000_0001);                  // ffff, group 6 zero
      add_addr(64'h0, 64'h0000_5efe_0000_0000);                  // isatap, zero v4
      add_addr(64'h0, 64'h0000_5efe_c0a8_0101);                  // isatap
      add_addr(64'h0, 64'h0000_0000_0a00_0001);                  // v4-compatible
      add_addr(64'h0, 64'h0000_1234_5678_9abc);                  // group 5 other
      add_addr(64'h0, 64'h0001_ffff_0102_0304);                  // group 4 set
      add_addr(64'h0000_0000_0000_0001, 64'h0002_0003_0004_0005); // run at start
      add_addr(64'h0001_0002_0003_0004, 64'h0);                  // run at end
      add_addr(64'h0001_0000_0000_0002, 64'h0000_0000_0003_0004); // tie
      add_addr(64'h0001_0000_0000_0002, 64'h0000_0000_0000_0003); // longer later
      add_addr(64'h0001_0000_0002_0003, 64'h0004_0005_0006_0007); // single zero
      add_addr(64'h0001_0012_0123_1234, 64'habcd_000f_00f0_0f00); // digit counts
      add_addr(64'hfe80_0000_0000_0000, 64'h0000_0000_0000_0001); // link-local
      add_addr(64'h1111_2222_3333_4444, 64'h5555_6666_7777_8888); // longest text
      add_addr(64'h0000_0001_0000_0001, 64'h0000_0001_0000_0001); // alternating zeros
      add_addr(64'hffff_0000_ffff_0000, 64'h0000_ffff_0000_ffff); // one run of two
      for (k = 0; k < NUM_RANDOM; k++) add_random_addr();
      total_items = pending_addrs.size();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (items_accepted != total_items || expected_chars.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // Driver: bursts of items with random gaps
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fired) begin
         // hold the offered item until it is taken
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left  <= gap_left - 1;
      end else if (pending_addrs.size() > 0) begin
         req_data  <= pending_addrs.pop_front();
         req_valid <= 1'b1;
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 60);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Receiver: changing stall pattern plus one long hold-off
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      rx_count <= rx_count + 1;
      if (rx_count % 50 == 0) rx_mode <= $urandom_range(0, 3);
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && items_accepted >= HOLD_AFTER) begin
         // Long stall while the sender keeps offering items
         rsp_ready <= 1'b0;
         hold_left <= LONG_HOLD;
         hold_done <= 1'b1;
      end else begin
         case (rx_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            2:       rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (rx_count[2:0] != 3'd0);
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Monitor: check characters, then predict newly accepted addresses
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      req_fired <= req_valid && req_ready && !reset;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected item, char %h last %b",
                        $time, rsp_data.text_char, rsp_data.last);
               error_count++;
            end else begin
               exp_char = expected_chars.pop_front();
               if (rsp_data.text_char !== exp_char.text_char ||
                   rsp_data.last !== exp_char.last) begin
                  $display("%0t: mismatch, expected char %h last %b, actual char %h last %b",
                           $time, exp_char.text_char, exp_char.last,
                           rsp_data.text_char, rsp_data.last);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            format_address(req_data);
            items_accepted++;
         end
      end
   end

   // Watchdog: too long without any item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= ACCEPT_TIMEOUT) begin
         $display("%0t: timeout, no item accepted for %0d cycles", $time, idle_cycles);
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

FILE: sim.f
src/ip6fmt_pkg.sv
src/ipv6_address_text_formatter.sv
test/tb.sv
